// ===== sv/bas_pkg.sv =====
// ----------------------------------------------------------------------------
// bas_pkg
// Shared constants, types and helper functions of the barometric altitude
// smoother: window geometry, register map, ALU op codes and saturation.
// ----------------------------------------------------------------------------
package bas_pkg;

   // window geometry and storage widths
   localparam int WINDOW        = 25;
   localparam int SAMPLE_BITS   = 32;
   localparam int RING_IDX_BITS = $clog2(WINDOW);
   localparam int SUM_BITS      = SAMPLE_BITS + $clog2(WINDOW);

   // divide-by-window unit: one quotient digit group per cycle
   localparam int REM_BITS     = $clog2(WINDOW);
   localparam int DIV_DIGIT    = 6;
   localparam int DIV_STEPS    = (SUM_BITS + DIV_DIGIT - 1) / DIV_DIGIT;
   localparam int DIV_BITS     = DIV_STEPS * DIV_DIGIT;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

   // field widths
   localparam int DATA_BITS   = 32;
   localparam int WEIGHT_BITS = 17;
   localparam int LEVEL_BITS  = 31;

   // register map
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 31;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMOOTHING_WEIGHT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_LIMIT       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_THRESHOLD   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_GAIN        = 2'd3;

   localparam logic [WEIGHT_BITS-1:0] RST_SMOOTHING_WEIGHT = 17'd655;
   localparam logic [LEVEL_BITS-1:0]  RST_STEP_LIMIT       = 31'd65536;
   localparam logic [LEVEL_BITS-1:0]  RST_STEP_THRESHOLD   = 31'd13107;
   localparam logic [WEIGHT_BITS-1:0] RST_STEP_GAIN        = 17'd10923;
   localparam logic [WEIGHT_BITS-1:0] ONE_Q16              = 17'd65536;

   // shared ALU
   localparam int ALU_BITS   = 36;
   localparam int MUL_A_BITS = 34;
   localparam int Q_SHIFT    = 16;
   localparam int PROD_BITS  = MUL_A_BITS + WEIGHT_BITS + 1;

   localparam logic [2:0] ALU_SUB    = 3'd0;
   localparam logic [2:0] ALU_MULQ   = 3'd1;
   localparam logic [2:0] ALU_ADDSAT = 3'd2;
   localparam logic [2:0] ALU_SUBSAT = 3'd3;
   localparam logic [2:0] ALU_CLAMP  = 3'd4;

   typedef logic signed [DATA_BITS-1:0]   data_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic signed [ALU_BITS-1:0]    alu_word_type;

   typedef struct packed {
      logic                   en;
      logic [2:0]             op;
      alu_word_type           a;
      alu_word_type           b;
      logic [WEIGHT_BITS-1:0] m;
   } alu_ctl_type;

   // clamp a 32-bit sample into the signed storage range
   function automatic sample_type sat_sample(input data_type x);
      longint v;
      longint smax;
      longint smin;
      v    = longint'(x);
      smax = (longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1);
      smin = -smax - longint'(1);
      if (v > smax) v = smax;
      if (v < smin) v = smin;
      return sample_type'(v);
   endfunction

   // sign-extend a 32-bit value to the ALU word
   function automatic alu_word_type ext_data(input data_type x);
      return {{(ALU_BITS - DATA_BITS){x[DATA_BITS-1]}}, x};
   endfunction

   // saturate a grown ALU sum to the signed 32-bit range
   function automatic alu_word_type sat_data(input logic signed [ALU_BITS:0] x);
      logic signed [ALU_BITS:0] hi;
      logic signed [ALU_BITS:0] lo;
      hi = (ALU_BITS + 1)'(64'sd2147483647);
      lo = (ALU_BITS + 1)'(-64'sd2147483648);
      if (x > hi) return hi[ALU_BITS-1:0];
      if (x < lo) return lo[ALU_BITS-1:0];
      return x[ALU_BITS-1:0];
   endfunction

endpackage

// ===== sv/bas_if.sv =====
// ----------------------------------------------------------------------------
// bas_req_if / bas_rsp_if
// Valid/ready channels carrying one altitude word in and one result word out.
// ----------------------------------------------------------------------------
interface bas_req_if;
   import bas_pkg::*;
   logic     valid;
   logic     ready;
   data_type altitude_sample;
   logic     latch_offset;

   modport source (output valid, output altitude_sample, output latch_offset, input ready);
   modport sink   (input valid, input altitude_sample, input latch_offset, output ready);
endinterface

interface bas_rsp_if;
   import bas_pkg::*;
   logic     valid;
   logic     ready;
   data_type fast_altitude;
   data_type slow_altitude;
   data_type relative_altitude;

   modport source (output valid, output fast_altitude, output slow_altitude,
                   output relative_altitude, input ready);
   modport sink   (input valid, input fast_altitude, input slow_altitude,
                   input relative_altitude, output ready);
endinterface

// ===== sv/bas_ring.sv =====
// ----------------------------------------------------------------------------
// bas_ring
// Sample window with its running sum. A write swaps the oldest sample for
// the new one; the difference is registered first and then added into the sum.
// ----------------------------------------------------------------------------
module bas_ring import bas_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  sample_type wr_sample,
   output sum_type    sum
);

   sample_type                   ring_ff [WINDOW];
   logic [WINDOW-1:0]            valid_ff, valid_in;
   logic [RING_IDX_BITS-1:0]     pos_ff, pos_in;
   sum_type                      sum_ff, sum_in;
   logic signed [SAMPLE_BITS:0]  delta_ff, delta_in;
   logic                         pend_ff, pend_in;
   sample_type                   old_sample;

   // entries never written read as zero
   assign old_sample = valid_ff[pos_ff] ? ring_ff[pos_ff] : '0;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      delta_in = delta_ff;
      pend_in  = 1'b0;
      sum_in   = sum_ff;
      if (pend_ff) begin
         sum_in = sum_ff + SUM_BITS'(delta_ff);
      end
      if (wr_en) begin
         valid_in[pos_ff] = 1'b1;
         delta_in = {wr_sample[SAMPLE_BITS-1], wr_sample}
                  - {old_sample[SAMPLE_BITS-1], old_sample};
         pend_in  = 1'b1;
         pos_in   = (pos_ff == RING_IDX_BITS'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pos_ff   <= '0;
         sum_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      if (wr_en) begin
         ring_ff[pos_ff] <= wr_sample;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== sv/bas_div.sv =====
// ----------------------------------------------------------------------------
// bas_div
// Signed divide of the window sum by WINDOW, truncated toward zero and
// saturated to 32 bits. Restoring division, DIV_DIGIT quotient bits a cycle.
// ----------------------------------------------------------------------------
module bas_div import bas_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  sum_type  sum,
   output logic     done,
   output data_type fast
);

   logic [DIV_BITS-1:0]     work_ff, work_in;
   logic [REM_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   data_type                fast_ff, fast_in;
   logic [SUM_BITS-1:0]     mag;
   logic [DIV_BITS-1:0]     step_work;
   logic [REM_BITS-1:0]     step_rem;
   logic [63:0]             quo;

   assign mag = sum[SUM_BITS-1] ? unsigned'(-sum) : unsigned'(sum);
   assign quo = 64'(work_ff);

   always_comb begin : digit_step
      logic [REM_BITS:0]   trial;
      logic [DIV_BITS-1:0] w;
      logic [REM_BITS-1:0] r;
      w = work_ff;
      r = rem_ff;
      for (int i = 0; i < DIV_DIGIT; i++) begin
         trial = {r, w[DIV_BITS-1]};
         w     = {w[DIV_BITS-2:0], 1'b0};
         if (trial >= (REM_BITS + 1)'(WINDOW)) begin
            trial = trial - (REM_BITS + 1)'(WINDOW);
            w[0]  = 1'b1;
         end
         r = trial[REM_BITS-1:0];
      end
      step_work = w;
      step_rem  = r;
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      fast_in = fast_ff;
      if (start) begin
         work_in = DIV_BITS'(mag);
         rem_in  = '0;
         cnt_in  = DIV_CNT_BITS'(DIV_STEPS);
         neg_in  = sum[SUM_BITS-1];
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff != '0) begin
         work_in = step_work;
         rem_in  = step_rem;
         cnt_in  = cnt_ff - 1'b1;
      end else if (busy_ff) begin
         // apply sign, saturate
         busy_in = 1'b0;
         done_in = 1'b1;
         if (!neg_ff) begin
            fast_in = (quo > 64'h7FFF_FFFF) ? data_type'(32'h7FFF_FFFF)
                                            : data_type'(quo[DATA_BITS-1:0]);
         end else begin
            fast_in = (quo > 64'h8000_0000) ? data_type'(32'h8000_0000)
                                            : data_type'(DATA_BITS'(-quo));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      fast_ff <= fast_in;
   end

   assign done = done_ff;
   assign fast = fast_ff;

endmodule

// ===== sv/bas_alu.sv =====
// ----------------------------------------------------------------------------
// bas_alu
// Shared arithmetic unit: subtract, Q1.16 multiply with floor, saturating
// add and subtract, and clamp with jump test. Result registered.
// ----------------------------------------------------------------------------
module bas_alu import bas_pkg::*; (
   input  logic                  clock,
   input  alu_ctl_type           ctl,
   input  logic [LEVEL_BITS-1:0] limit,
   input  logic [LEVEL_BITS-1:0] threshold,
   output alu_word_type          result,
   output logic                  jump
);

   alu_word_type               result_ff, result_in;
   logic                       jump_ff, jump_in;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [ALU_BITS:0]   sum_w;
   logic signed [ALU_BITS:0]   diff_w;
   alu_word_type               lim_pos, lim_neg, thr_pos, thr_neg, clamped;

   assign prod    = $signed(ctl.a[MUL_A_BITS-1:0]) * $signed({1'b0, ctl.m});
   assign sum_w   = {ctl.a[ALU_BITS-1], ctl.a} + {ctl.b[ALU_BITS-1], ctl.b};
   assign diff_w  = {ctl.a[ALU_BITS-1], ctl.a} - {ctl.b[ALU_BITS-1], ctl.b};
   assign lim_pos = $signed(ALU_BITS'(limit));
   assign lim_neg = -lim_pos;
   assign thr_pos = $signed(ALU_BITS'(threshold));
   assign thr_neg = -thr_pos;
   assign clamped = (ctl.a > lim_pos) ? lim_pos : ((ctl.a < lim_neg) ? lim_neg : ctl.a);

   always_comb begin
      result_in = result_ff;
      jump_in   = jump_ff;
      case (ctl.op)
         ALU_SUB:    result_in = diff_w[ALU_BITS-1:0];
         ALU_MULQ:   result_in = prod[Q_SHIFT +: ALU_BITS];
         ALU_ADDSAT: result_in = sat_data(sum_w);
         ALU_SUBSAT: result_in = sat_data(diff_w);
         ALU_CLAMP: begin
            result_in = clamped;
            // |clamped| > thr  <=>  |a| > thr and limit > thr
            jump_in   = (limit > threshold) && ((ctl.a > thr_pos) || (ctl.a < thr_neg));
         end
         default:    result_in = result_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         result_ff <= result_in;
         jump_ff   <= jump_in;
      end
   end

   assign result = result_ff;
   assign jump   = jump_ff;

endmodule

// ===== sv/baro_altitude_smoother.sv =====
// ----------------------------------------------------------------------------
// baro_altitude_smoother
// Moving average of the last WINDOW altitude samples feeding an exponential
// smoother with step correction and a latchable ground offset.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one word: a signed Q15.16 altitude sample and a latch flag.
//   rsp_chan returns one word per request: fast (window mean), slow (smoothed,
//   step corrected) and relative (slow minus ground offset), all Q15.16.
//   csr_* writes the four tuning registers; write only while no word is in
//   flight.
// Sequence:
//   The window mean is produced by a restoring divider that retires
//   DIV_DIGIT quotient bits a cycle, then one shared ALU runs eight
//   dependent steps. req_chan.ready is high only when the block is empty,
//   so a new word is taken only after the previous result has been taken.
// Reset:
//   Synchronous. Clears the window, the sum, the slow track and the offset
//   and loads the register defaults; no clearing pass is needed.
// Stall:
//   A result stays on rsp_chan unchanged until taken; no new request is
//   taken meanwhile.
// ----------------------------------------------------------------------------
module baro_altitude_smoother import bas_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   bas_req_if.sink                   req_chan,
   bas_rsp_if.source                 rsp_chan
);

   // sequencer codes
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RING     = 4'd1;
   localparam logic [3:0] S_DIV_GO   = 4'd2;
   localparam logic [3:0] S_DIV_WAIT = 4'd3;
   localparam logic [3:0] S_D1       = 4'd4;
   localparam logic [3:0] S_M1       = 4'd5;
   localparam logic [3:0] S_A1       = 4'd6;
   localparam logic [3:0] S_D2       = 4'd7;
   localparam logic [3:0] S_CL       = 4'd8;
   localparam logic [3:0] S_M2       = 4'd9;
   localparam logic [3:0] S_A2       = 4'd10;
   localparam logic [3:0] S_REL      = 4'd11;
   localparam logic [3:0] S_OUT      = 4'd12;

   logic [3:0]             state_ff, state_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [LEVEL_BITS-1:0]  limit_ff, limit_in;
   logic [LEVEL_BITS-1:0]  thresh_ff, thresh_in;
   logic [WEIGHT_BITS-1:0] gain_ff, gain_in;
   data_type               slow_ff, slow_in;
   data_type               offset_ff, offset_in;
   logic                   latch_ff, latch_in;

   logic                   accept;
   logic [WEIGHT_BITS-1:0] weight_eff, gain_eff;
   sum_type                window_sum;
   logic                   div_done;
   data_type               fast;
   alu_ctl_type            alu_ctl;
   alu_word_type           alu_result;
   logic                   alu_jump;
   data_type               slow_new, offset_new;

   assign accept = req_chan.valid && req_chan.ready;

   // weights above one act as one
   assign weight_eff = (weight_ff > ONE_Q16) ? ONE_Q16 : weight_ff;
   assign gain_eff   = (gain_ff > ONE_Q16) ? ONE_Q16 : gain_ff;

   bas_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept),
      .wr_sample (sat_sample(req_chan.altitude_sample)),
      .sum       (window_sum)
   );

   bas_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DIV_GO),
      .sum   (window_sum),
      .done  (div_done),
      .fast  (fast)
   );

   bas_alu u_alu (
      .clock     (clock),
      .ctl       (alu_ctl),
      .limit     (limit_ff),
      .threshold (thresh_ff),
      .result    (alu_result),
      .jump      (alu_jump)
   );

   // slow value after the optional jump, and the offset it may latch
   assign slow_new   = alu_jump ? alu_result[DATA_BITS-1:0] : slow_ff;
   assign offset_new = latch_ff ? slow_new : offset_ff;

   // configuration writes
   always_comb begin
      weight_in = weight_ff;
      limit_in  = limit_ff;
      thresh_in = thresh_ff;
      gain_in   = gain_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SMOOTHING_WEIGHT: weight_in = csr_wdata[WEIGHT_BITS-1:0];
            CSR_STEP_LIMIT:       limit_in  = csr_wdata[LEVEL_BITS-1:0];
            CSR_STEP_THRESHOLD:   thresh_in = csr_wdata[LEVEL_BITS-1:0];
            CSR_STEP_GAIN:        gain_in   = csr_wdata[WEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer: drive the shared ALU one step per state
   always_comb begin
      state_in  = state_ff;
      slow_in   = slow_ff;
      offset_in = offset_ff;
      latch_in  = latch_ff;
      alu_ctl   = '{en: 1'b0, op: ALU_SUB, a: '0, b: '0, m: '0};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               latch_in = req_chan.latch_offset;
               state_in = S_RING;
            end
         end
         S_RING:     state_in = S_DIV_GO;
         S_DIV_GO:   state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_done) state_in = S_D1;
         end
         S_D1: begin
            // fast - slow
            alu_ctl  = '{en: 1'b1, op: ALU_SUB, a: ext_data(fast), b: ext_data(slow_ff), m: '0};
            state_in = S_M1;
         end
         S_M1: begin
            alu_ctl  = '{en: 1'b1, op: ALU_MULQ, a: alu_result, b: '0, m: weight_eff};
            state_in = S_A1;
         end
         S_A1: begin
            alu_ctl  = '{en: 1'b1, op: ALU_ADDSAT, a: ext_data(slow_ff), b: alu_result, m: '0};
            state_in = S_D2;
         end
         S_D2: begin
            // hold the smoothed value, take the new difference
            slow_in  = alu_result[DATA_BITS-1:0];
            alu_ctl  = '{en: 1'b1, op: ALU_SUB, a: ext_data(fast), b: alu_result, m: '0};
            state_in = S_CL;
         end
         S_CL: begin
            alu_ctl  = '{en: 1'b1, op: ALU_CLAMP, a: alu_result, b: '0, m: '0};
            state_in = S_M2;
         end
         S_M2: begin
            alu_ctl  = '{en: 1'b1, op: ALU_MULQ, a: alu_result, b: '0, m: gain_eff};
            state_in = S_A2;
         end
         S_A2: begin
            alu_ctl  = '{en: 1'b1, op: ALU_ADDSAT, a: ext_data(slow_ff), b: alu_result, m: '0};
            state_in = S_REL;
         end
         S_REL: begin
            // commit slow, latch offset, relative = slow - offset
            slow_in   = slow_new;
            offset_in = offset_new;
            alu_ctl   = '{en: 1'b1, op: ALU_SUBSAT, a: ext_data(slow_new),
                          b: ext_data(offset_new), m: '0};
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (rsp_chan.ready) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         weight_ff <= RST_SMOOTHING_WEIGHT;
         limit_ff  <= RST_STEP_LIMIT;
         thresh_ff <= RST_STEP_THRESHOLD;
         gain_ff   <= RST_STEP_GAIN;
         slow_ff   <= '0;
         offset_ff <= '0;
         latch_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         weight_ff <= weight_in;
         limit_ff  <= limit_in;
         thresh_ff <= thresh_in;
         gain_ff   <= gain_in;
         slow_ff   <= slow_in;
         offset_ff <= offset_in;
         latch_ff  <= latch_in;
      end
   end

   assign req_chan.ready             = (state_ff == S_IDLE);
   assign rsp_chan.valid             = (state_ff == S_OUT);
   assign rsp_chan.fast_altitude     = fast;
   assign rsp_chan.slow_altitude     = slow_ff;
   assign rsp_chan.relative_altitude = alu_result[DATA_BITS-1:0];

   a_accept_starts_ring: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_RING))
      else $error("accepted word did not start the window update");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a result is pending");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider finished outside the wait state");

   a_rel_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |->
         ((&alu_result[ALU_BITS-1:DATA_BITS-1]) || !(|alu_result[ALU_BITS-1:DATA_BITS-1])))
      else $error("relative altitude not saturated to 32 bits");

   a_rel_zero_on_latch: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && latch_ff) |-> (alu_result == '0))
      else $error("relative altitude nonzero right after offset latch");

endmodule

// ===== dv/baro_altitude_smoother_test.sv =====
// ----------------------------------------------------------------------------
// baro_altitude_smoother_test
// Self-checking bench for the barometric altitude smoother. Sends altitude
// words with random gaps and latch requests, predicts fast, slow and relative
// altitude per word in a scoreboard, and checks every result word in order
// across several tuning register settings.
// ----------------------------------------------------------------------------
module baro_altitude_smoother_test import bas_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HOLD_CYCLES  = 300;  // long receiver hold-off
   localparam int unsigned QUIET_LIMIT  = 4000; // cycles with no traffic
   localparam int          TAIL_CYCLES  = 40;   // settle time after the last word
   localparam longint      DATA_MAX     = 64'sd2147483647;
   localparam longint      DATA_MIN     = -64'sd2147483648;

   typedef struct {
      data_type fast;
      data_type slow;
      data_type relative;
   } altitude_word_type;

   // Scoreboard: tracks the window, the slow track and the ground offset,
   // and queues one expected result word per accepted sample.
   class altitude_scoreboard;
      longint            ring [WINDOW];
      int unsigned       slot;
      longint            window_sum;
      longint            slow_level;
      longint            offset_level;
      longint            alpha;
      longint            limit;
      longint            threshold;
      longint            gain;
      altitude_word_type expected_words [$];
      int unsigned       mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         foreach (ring[i]) ring[i] = 0;
         slot         = 0;
         window_sum   = 0;
         slow_level   = 0;
         offset_level = 0;
         alpha        = longint'(RST_SMOOTHING_WEIGHT);
         limit        = longint'(RST_STEP_LIMIT);
         threshold    = longint'(RST_STEP_THRESHOLD);
         gain         = longint'(RST_STEP_GAIN);
         expected_words.delete();
      endfunction

      function longint clip32(longint v);
         if (v > DATA_MAX) return DATA_MAX;
         if (v < DATA_MIN) return DATA_MIN;
         return v;
      endfunction

      // weights above one count as exactly one
      function longint weight_of(longint w);
         return (w > longint'(ONE_Q16)) ? longint'(ONE_Q16) : w;
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_SMOOTHING_WEIGHT: alpha     = longint'(value[WEIGHT_BITS-1:0]);
            CSR_STEP_LIMIT:       limit     = longint'(value[LEVEL_BITS-1:0]);
            CSR_STEP_THRESHOLD:   threshold = longint'(value[LEVEL_BITS-1:0]);
            CSR_STEP_GAIN:        gain      = longint'(value[WEIGHT_BITS-1:0]);
            default: ;
         endcase
      endfunction

      function void note_sample(data_type altitude, logic latch);
         longint            s;
         longint            smax;
         longint            fast;
         longint            slow;
         longint            diff;
         longint            mag;
         altitude_word_type w;
         smax = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
         s    = longint'(altitude);
         if (s > smax) s = smax;
         if (s < -smax - 1) s = -smax - 1;

         if (slot >= WINDOW) slot = 0;
         window_sum = window_sum - ring[slot] + s;
         ring[slot] = s;
         slot++;
         if (slot >= WINDOW) slot = 0;

         // mean truncates toward zero; weighted products floor
         fast = clip32(window_sum / WINDOW);
         slow = clip32(slow_level + (((fast - slow_level) * weight_of(alpha)) >>> Q_SHIFT));
         diff = fast - slow;
         if (diff > limit) diff = limit;
         if (diff < -limit) diff = -limit;
         mag = (diff < 0) ? -diff : diff;
         if (mag > threshold)
            slow = clip32(slow + ((diff * weight_of(gain)) >>> Q_SHIFT));
         slow_level = slow;
         if (latch) offset_level = slow;

         w.fast     = data_type'(fast);
         w.slow     = data_type'(slow);
         w.relative = data_type'(clip32(slow - offset_level));
         expected_words.push_back(w);
      endfunction

      function void compare_field(string name, data_type expected, data_type actual);
         if (expected !== actual) begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", name, expected, actual);
         end
      endfunction

      function void check_result(data_type fast, data_type slow, data_type relative);
         altitude_word_type w;
         if (expected_words.size() == 0) begin
            mismatches++;
            $error("unexpected result word: fast %0d slow %0d relative %0d",
                   fast, slow, relative);
            return;
         end
         w = expected_words.pop_front();
         compare_field("fast_altitude", w.fast, fast);
         compare_field("slow_altitude", w.slow, slow);
         compare_field("relative_altitude", w.relative, relative);
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   bas_req_if req_chan ();
   bas_rsp_if rsp_chan ();

   altitude_scoreboard sb = new();

   // steady: no idling on either side; hold_request: ask for a long hold-off
   bit steady       = 1'b0;
   bit hold_request = 1'b0;

   baro_altitude_smoother dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Check every result word taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result(rsp_chan.fast_altitude, rsp_chan.slow_altitude,
                         rsp_chan.relative_altitude);
   end

   // Receiver: drop ready with a chance of about 8 in a hundred; on request, hold ready
   // low for a long stretch so the block fills and stalls its input.
   initial begin : result_sink
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request   = 1'b0;
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_chan.ready = steady || ($urandom_range(99) >= 8);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             csr_wr_en)
            quiet = 0;
         else
            quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Offer one altitude word and hold it until the block takes it.
   task automatic send_sample(data_type altitude, logic latch);
      @(negedge clock);
      req_chan.valid           = 1'b1;
      req_chan.altitude_sample = altitude;
      req_chan.latch_offset    = latch;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_sample(altitude, latch);
   endtask

   // Drop valid for as many cycles as asked; scramble the payload meanwhile.
   task automatic idle_sender(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid           = 1'b0;
         req_chan.altitude_sample = data_type'($urandom());
         req_chan.latch_offset    = 1'($urandom());
      end
   endtask

   // Stop offering and wait until every expected word has come back.
   task automatic drain_block();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      sb.set_register(index, value);
   endtask

   // Write all four tuning registers while the block is empty.
   task automatic configure(logic [CSR_DATA_BITS-1:0] weight,
                            logic [CSR_DATA_BITS-1:0] step_limit,
                            logic [CSR_DATA_BITS-1:0] step_threshold,
                            logic [CSR_DATA_BITS-1:0] step_gain);
      drain_block();
      write_register(CSR_SMOOTHING_WEIGHT, weight);
      write_register(CSR_STEP_LIMIT, step_limit);
      write_register(CSR_STEP_THRESHOLD, step_threshold);
      write_register(CSR_STEP_GAIN, step_gain);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Random altitude runs: hold a level (rail, random or near ground) with
   // some noise, or full-range noise, in runs of 10 to 40 words, so fast and
   // slow swing to extremes and the offset and clamp paths get exercised.
   task automatic run_altitude(int unsigned count);
      int unsigned sent;
      int unsigned run_len;
      int unsigned k;
      longint      level;
      longint      spread;
      longint      v;
      data_type    altitude;
      sent = 0;
      while (sent < count) begin
         run_len = $urandom_range(10, 40);
         case ($urandom_range(7))
            0:       level = DATA_MAX;
            1:       level = DATA_MIN;
            2:       level = longint'(data_type'($urandom()));
            default: level = longint'($urandom_range(0, 32'h0200_0000)) - 64'sd16777216;
         endcase
         case ($urandom_range(4))
            0:       spread = 0;
            1:       spread = 256;
            2:       spread = 65536;
            3:       spread = 64'sd4194304;
            default: spread = -1;  // full-range noise
         endcase
         for (k = 0; k < run_len && sent < count; k++) begin
            if (spread < 0) begin
               altitude = data_type'($urandom());
            end else begin
               v = level + longint'($urandom_range(0, 32'(2 * spread))) - spread;
               if (v > DATA_MAX) v = DATA_MAX;
               if (v < DATA_MIN) v = DATA_MIN;
               altitude = data_type'(v);
            end
            if (!steady && $urandom_range(99) < 8)
               idle_sender($urandom_range(1, 6));
            send_sample(altitude, $urandom_range(9) == 0);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      // Hold every input at a known value with reset asserted, then release it.
      reset                    = 1'b1;
      csr_wr_en                = 1'b0;
      csr_index                = CSR_SMOOTHING_WEIGHT;
      csr_wdata                = '0;
      req_chan.valid           = 1'b0;
      req_chan.altitude_sample = '0;
      req_chan.latch_offset    = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed words at reset defaults: rails, sign edges, unit steps,
      // threshold-sized steps, and latch requests on both rails.
      send_sample(32'sh0000_0000, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b1);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh8000_0000, 1'b1);
      send_sample(32'shFFFF_FFFF, 1'b0);
      send_sample(32'sh0000_0001, 1'b0);
      send_sample(32'sh0001_0000, 1'b0);
      send_sample(32'shFFFF_0000, 1'b0);
      send_sample(32'sh0000_3333, 1'b0);
      send_sample(32'sh0000_3334, 1'b1);
      send_sample(32'sh5555_5555, 1'b0);
      send_sample(32'shAAAA_AAAA, 1'b0);
      send_sample(32'sh0064_0000, 1'b0);
      send_sample(32'sh0064_0000, 1'b1);
      send_sample(32'shFF9C_0000, 1'b0);
      send_sample(32'sh0000_0000, 1'b0);
      send_sample(32'sh0000_0000, 1'b1);
      run_altitude(150);

      // Weights at one, no clamp, jump on any nonzero difference.
      configure(31'd65536, 31'h7FFF_FFFF, 31'd0, 31'd65536);
      run_altitude(150);

      // Weights at zero, clamp to zero, never jump; no idling here.
      configure(31'd0, 31'd0, 31'h7FFF_FFFF, 31'd0);
      steady = 1'b1;
      run_altitude(150);
      steady = 1'b0;

      // Weights above one; mid-phase, hold the receiver off for a long stretch.
      configure(31'h1_FFFF, 31'($urandom_range(0, 32'h0010_0000)), 31'd0, 31'h1_FFFF);
      run_altitude(60);
      hold_request = 1'b1;
      run_altitude(100);

      // Random registers; pause the sender until every result is back.
      configure(31'($urandom_range(0, 65536)), 31'($urandom()),
                31'($urandom_range(0, 32'h0004_0000)), 31'($urandom_range(0, 32'h1_FFFF)));
      run_altitude(70);
      drain_block();
      run_altitude(80);

      // Small alpha, tight clamp and threshold near the step size.
      configure(31'($urandom_range(1, 2000)), 31'($urandom_range(1, 32'h0004_0000)),
                31'($urandom_range(0, 32'h0002_0000)), 31'($urandom_range(0, 65536)));
      run_altitude(170);

      // Let the last words drain, then report.
      drain_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bas_pkg.sv
sv/bas_if.sv
sv/bas_ring.sv
sv/bas_div.sv
sv/bas_alu.sv
sv/baro_altitude_smoother.sv
dv/baro_altitude_smoother_test.sv
